FILE: rtl/core/msp_pkg.sv
// Shared types and constants for the multi-axis step pulse generator.
`default_nettype none

package msp_pkg;

  localparam int unsigned SelW      = 3;
  localparam int unsigned PosW      = 16;
  localparam int unsigned DlyW      = 15;
  localparam int unsigned WakeW     = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned VisAxes   = 3;
  localparam int unsigned MaxMotors = 8;

  localparam int unsigned MotorCountDef = 3;

  localparam logic [PosW-1:0]  TopLimitRst     = 16'd45000;
  localparam logic [DlyW-1:0]  DefaultDelayRst = 15'd125;
  localparam logic [WakeW-1:0] WakeTicksRst    = 16'd5000;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_BAD_MOTOR = 2'd1,
    ERR_LIMIT     = 2'd2,
    ERR_BUSY      = 2'd3
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOP_LIMIT     = 2'd0,
    CFG_DEFAULT_DELAY = 2'd1,
    CFG_WAKE_TICKS    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_SET  = 1'b1
  } action_e;

  // Per-axis control for one request.
  typedef struct packed {
    logic            commit;
    logic            set;
    logic            start;
    logic            step;
    logic [PosW-1:0] goal;
    logic [DlyW-1:0] delay;
  } axis_ctrl_t;

  // Per-axis status: current off-target flag and next-state values.
  typedef struct packed {
    logic            off_q;
    logic            off_d;
    logic [PosW-1:0] pos_d;
    logic            step_d;
    logic            dir_d;
  } axis_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/msp_if.sv
// Handshake interfaces for the request, result and configuration channels.
`default_nettype none

interface msp_in_if import msp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            action;
  logic [SelW-1:0] motor_select;
  logic [PosW-1:0] goal_position;
  logic [DlyW-1:0] half_period;

  modport source (output valid, action, motor_select, goal_position, half_period,
                  input ready);
  modport sink   (input valid, action, motor_select, goal_position, half_period,
                  output ready);
endinterface

interface msp_out_if import msp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VisAxes-1:0] step_lines;
  logic [VisAxes-1:0] dir_lines;
  logic               drive_enable;
  logic               busy_res;
  logic               move_done;
  logic [1:0]         error_code;
  logic [PosW-1:0]    selected_position;

  modport source (output valid, step_lines, dir_lines, drive_enable, busy_res,
                  move_done, error_code, selected_position, input ready);
  modport sink   (input valid, step_lines, dir_lines, drive_enable, busy_res,
                  move_done, error_code, selected_position, output ready);
endinterface

interface msp_cfg_if import msp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/msp_axis.sv
// One stepper axis: position, target, half-period, step timer and line levels.
`default_nettype none

module msp_axis import msp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  axis_ctrl_t ctrl_i,
  output axis_stat_t stat_o
);

  logic [PosW-1:0] pos_q, pos_d, tgt_q, tgt_d;
  logic [DlyW-1:0] dly_q, dly_d, ela_q, ela_d, ela_inc;
  logic            stp_q, stp_d, dir_q, dir_d;
  logic            off, up;

  assign off     = (pos_q != tgt_q);
  assign up      = (tgt_q > pos_q);
  assign ela_inc = ela_q + 15'd1;

  always_comb begin
    pos_d = pos_q;
    tgt_d = tgt_q;
    dly_d = dly_q;
    ela_d = ela_q;
    stp_d = stp_q;
    dir_d = dir_q;
    if (ctrl_i.set) begin
      tgt_d = ctrl_i.goal;
      dly_d = ctrl_i.delay;
    end
    if (ctrl_i.start) begin
      if (off) begin
        dir_d = up;
      end
      ela_d = '0;
    end
    if (ctrl_i.step && off) begin
      // The timer wraps to zero, which also counts as expiry.
      if ((ela_inc >= dly_q) || (ela_inc == '0)) begin
        ela_d = '0;
        stp_d = ~stp_q;
        // A falling step edge moves the axis one step.
        if (stp_q) begin
          pos_d = up ? (pos_q + 16'd1) : (pos_q - 16'd1);
        end
      end else begin
        ela_d = ela_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tgt_q <= '0;
      dly_q <= DefaultDelayRst;
      ela_q <= '0;
      stp_q <= 1'b0;
      dir_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      pos_q <= pos_d;
      tgt_q <= tgt_d;
      dly_q <= dly_d;
      ela_q <= ela_d;
      stp_q <= stp_d;
      dir_q <= dir_d;
    end
  end

  assign stat_o.off_q  = off;
  assign stat_o.off_d  = (pos_d != tgt_d);
  assign stat_o.pos_d  = pos_d;
  assign stat_o.step_d = stp_d;
  assign stat_o.dir_d  = dir_d;

endmodule

`default_nettype wire

FILE: rtl/core/multi_axis_step_pulse_generator_unit.sv
// Top level of the multi-axis step and direction pulse generator.
// Usage: each request on in_i is either a one-microsecond tick or a set-target
// command for one motor. Every request yields exactly one result on out_o with
// the step and direction line levels, the drive enable, the busy flag, a
// move-done pulse, an error code for set-target commands and the position of
// the selected motor. Configuration registers (top limit, default half-period,
// wake time) are written over cfg_i, which is always ready; write them only
// while the block is idle.
// A request is loaded into the request register at the accepting edge, and the
// axis update fills the result register from it as soon as the result register
// is free or being taken by the receiver.
// Throughput is one request per cycle; all axis timers update in parallel in
// the single update stage, so nothing limits the rate but the handshakes.
// When the receiver stalls, the result register holds its value and the
// request register fills; once both are full, in_i.ready drops until the
// receiver takes a result.
// Reset clears all positions and targets to zero, sets every axis half-period
// to 125 ticks, drops the drive enable and loads the register defaults.
`default_nettype none

module multi_axis_step_pulse_generator_unit import msp_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = MotorCountDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msp_in_if.sink    in_i,
  msp_out_if.source out_o,
  msp_cfg_if.sink   cfg_i
);

  localparam logic [SelW:0] MotorCountW = (SelW+1)'(MOTOR_COUNT);

  // Configuration registers.
  logic [PosW-1:0]  top_limit_q;
  logic [DlyW-1:0]  default_delay_q;
  logic [WakeW-1:0] wake_ticks_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_limit_q     <= TopLimitRst;
      default_delay_q <= DefaultDelayRst;
      wake_ticks_q    <= WakeTicksRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_TOP_LIMIT:     top_limit_q     <= cfg_i.data;
        CFG_DEFAULT_DELAY: default_delay_q <= cfg_i.data[DlyW-1:0];
        CFG_WAKE_TICKS:    wake_ticks_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Request register.
  logic            req_valid_q;
  logic            req_action_q;
  logic [SelW-1:0] req_sel_q;
  logic [PosW-1:0] req_goal_q;
  logic [DlyW-1:0] req_half_q;
  logic            out_valid_q;
  logic            advance;

  assign advance    = req_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      req_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      req_action_q <= in_i.action;
      req_sel_q    <= in_i.motor_select;
      req_goal_q   <= in_i.goal_position;
      req_half_q   <= in_i.half_period;
    end
  end

  // Move sequencing state.
  logic             enabled_q, enabled_d;
  logic [WakeW-1:0] wake_q, wake_d;

  axis_ctrl_t ctrl [MOTOR_COUNT];
  axis_stat_t stat [MOTOR_COUNT];

  logic            any_off_q, any_off_d;
  logic            is_tick, sel_bad, set_ok, start, wake_dec, stepping, done;
  err_e            err;
  logic [DlyW-1:0] set_delay;

  always_comb begin
    any_off_q = 1'b0;
    any_off_d = 1'b0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      any_off_q = any_off_q | stat[i].off_q;
      any_off_d = any_off_d | stat[i].off_d;
    end
  end

  assign is_tick = (action_e'(req_action_q) == ACT_TICK);
  assign sel_bad = ({1'b0, req_sel_q} >= MotorCountW);

  // Set-target checks in priority order: motor, limit, busy.
  always_comb begin
    if (is_tick) begin
      err = ERR_OK;
    end else if (sel_bad) begin
      err = ERR_BAD_MOTOR;
    end else if (req_goal_q > top_limit_q) begin
      err = ERR_LIMIT;
    end else if (enabled_q) begin
      err = ERR_BUSY;
    end else begin
      err = ERR_OK;
    end
  end

  assign set_ok    = !is_tick && (err == ERR_OK);
  assign set_delay = (req_half_q != '0) ? req_half_q : default_delay_q;
  assign start     = is_tick && !enabled_q && any_off_q;
  assign wake_dec  = is_tick && enabled_q && (wake_q != '0);
  assign stepping  = is_tick && enabled_q && (wake_q == '0);
  assign done      = stepping && !any_off_d;

  always_comb begin
    enabled_d = enabled_q;
    wake_d    = wake_q;
    if (start) begin
      enabled_d = 1'b1;
      wake_d    = wake_ticks_q;
    end else if (wake_dec) begin
      wake_d = wake_q - 16'd1;
    end else if (done) begin
      enabled_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      wake_q    <= '0;
    end else if (advance) begin
      enabled_q <= enabled_d;
      wake_q    <= wake_d;
    end
  end

  // Axes.
  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_axis
    always_comb begin
      ctrl[g].commit = advance;
      ctrl[g].set    = set_ok && (req_sel_q == SelW'(g));
      ctrl[g].start  = start;
      ctrl[g].step   = stepping;
      ctrl[g].goal   = req_goal_q;
      ctrl[g].delay  = set_delay;
    end

    msp_axis u_axis (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[g]),
      .stat_o (stat[g])
    );
  end

  // Result assembly. Only the first three motors appear on the line outputs.
  logic [VisAxes-1:0] steps_d, dirs_d;
  logic [PosW-1:0]    sel_pos_d;

  always_comb begin
    steps_d   = '0;
    dirs_d    = '0;
    sel_pos_d = '0;
    for (int i = 0; i < VisAxes; i++) begin
      if (i < MOTOR_COUNT) begin
        steps_d[i] = stat[i].step_d;
        dirs_d[i]  = stat[i].dir_d;
      end
    end
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (req_sel_q == SelW'(i)) begin
        sel_pos_d = stat[i].pos_d;
      end
    end
  end

  // Result register.
  logic [VisAxes-1:0] out_steps_q, out_dirs_q;
  logic               out_enable_q, out_busy_q, out_done_q;
  err_e               out_err_q;
  logic [PosW-1:0]    out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_steps_q  <= steps_d;
      out_dirs_q   <= dirs_d;
      out_enable_q <= enabled_d;
      out_busy_q   <= any_off_d;
      out_done_q   <= done;
      out_err_q    <= err;
      out_pos_q    <= sel_pos_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.step_lines        = out_steps_q;
  assign out_o.dir_lines         = out_dirs_q;
  assign out_o.drive_enable      = out_enable_q;
  assign out_o.busy_res          = out_busy_q;
  assign out_o.move_done         = out_done_q;
  assign out_o.error_code        = out_err_q;
  assign out_o.selected_position = out_pos_q;

`ifndef SYNTHESIS
  // The wake counter only runs while the drivers are enabled.
  a_wake_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wake_q != '0) |-> enabled_q)
    else $error("wake counter running with drivers disabled");

  // A finished move always drops the drive enable in the same result.
  a_done_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> (!out_enable_q && !out_busy_q))
    else $error("move done reported while still enabled or busy");

  // Every request leaving the request register lands in the result register.
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after update stage");
`endif

endmodule

`default_nettype wire
